// ===== hdl/swr_pkg.sv =====
// Shared constants and codes for the stack_with_roll block.
// No dependencies; used by hdl/stack_with_roll.sv.
`default_nettype none

package swr_pkg;

   localparam int STACK_DEPTH = 16;   // entries held, 2..31
   localparam int WORD_WIDTH  = 32;   // stored word width, 8..64

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   // fixed transaction field widths
   localparam int DATA_W = 32;
   localparam int N_W    = 5;
   localparam int K_W    = 8;
   localparam int FILL_W = 5;
   localparam int OP_W   = 2;

   localparam int CMP_W = (CNT_W > N_W) ? CNT_W : N_W;
   localparam int EXT_W = (WORD_WIDTH > DATA_W) ? WORD_WIDTH : DATA_W;

   // shift is reduced modulo count one quotient bit per cycle
   localparam int MOD_STEPS = K_W;
   localparam int STEP_W    = $clog2(MOD_STEPS);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_ROLL = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_ROLL_RANGE = 2'd1,
      STAT_UNDERFLOW  = 2'd2,
      STAT_OVERFLOW   = 2'd3
   } status_type;

endpackage

`default_nettype wire

// ===== hdl/stack_with_roll.sv =====
// Bounded stack of signed words with push, pop and roll.
// Depends on hdl/swr_pkg.sv.
//
// Usage:
//  - req_* is the request channel, rsp_* the response channel; both are
//    valid/ready. Every request transaction yields exactly one response.
//  - op push stores req_push_value on top, pop returns the top word in
//    rsp_pop_value, roll rotates the top req_roll_count entries by
//    req_roll_shift steps (top entry moves toward the bottom of the group).
//  - rsp_status flags overflow, underflow and a roll count above the fill
//    level; in those cases the stack is left as it was. rsp_fill_level is
//    the entry count after the transaction.
//  - Path from acceptance to rsp_valid: push, errors, zero count rolls and
//    unused op codes go straight to the done state; pop passes a pop state
//    for the registered memory read; a roll of n entries runs shift
//    reduction in the shared subtractor, copies the group into a scratch
//    memory, drains, writes the group back rotated and flushes before done.
//    req_ready rises together with rsp_valid, so the next request can be
//    taken in that cycle.
//  - One request at a time: req_ready is high only while the sequencer is
//    idle. The response sits in an output register, so a new request is
//    taken while a previous response still waits for rsp_ready; a stalled
//    receiver only holds the sequencer once the next response is finished.
//  - Reset (synchronous, active high) empties the stack and drops any
//    pending response. Memory contents are not cleared.
`default_nettype none

module stack_with_roll (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [swr_pkg::OP_W-1:0]               req_op,
   input  wire logic signed [swr_pkg::DATA_W-1:0]      req_push_value,
   input  wire logic [swr_pkg::N_W-1:0]                req_roll_count,
   input  wire logic [swr_pkg::K_W-1:0]                req_roll_shift,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [swr_pkg::DATA_W-1:0]           rsp_pop_value,
   output logic [1:0]                                  rsp_status,
   output logic [swr_pkg::FILL_W-1:0]                  rsp_fill_level
);

   localparam int ADDR_W = swr_pkg::ADDR_W;
   localparam int CNT_W  = swr_pkg::CNT_W;
   localparam int N_W    = swr_pkg::N_W;
   localparam int K_W    = swr_pkg::K_W;
   localparam int CMP_W  = swr_pkg::CMP_W;
   localparam int EXT_W  = swr_pkg::EXT_W;
   localparam int DATA_W = swr_pkg::DATA_W;
   localparam int WORD_W = swr_pkg::WORD_WIDTH;
   localparam int STEP_W = swr_pkg::STEP_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_MOD,
      S_COPY,
      S_DRAIN,
      S_WBACK,
      S_FLUSH,
      S_DONE
   } state_type;

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [N_W-1:0]           n_ff, n_in;
   logic [K_W-1:0]           k_ff, k_in;          // shift, consumed msb first
   logic [N_W-1:0]           r_ff, r_in;          // remainder = shift mod n
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [N_W-1:0]           i_ff, i_in;          // depth index from top
   logic [N_W-1:0]           j_ff, j_in;          // rotated source index
   logic [N_W-1:0]           left_ff, left_in;    // entries left after this one
   logic [ADDR_W-1:0]        top_ff, top_in;
   logic [DATA_W-1:0]        res_pop_ff, res_pop_in;
   swr_pkg::status_type      res_stat_ff, res_stat_in;
   logic                     copy_pend_ff, copy_pend_in;
   logic [ADDR_W-1:0]        copy_idx_ff, copy_idx_in;
   logic                     wb_pend_ff, wb_pend_in;
   logic [ADDR_W-1:0]        wb_addr_ff, wb_addr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        rsp_pop_ff, rsp_pop_in;
   swr_pkg::status_type      rsp_stat_ff, rsp_stat_in;
   logic [swr_pkg::FILL_W-1:0] rsp_fill_ff, rsp_fill_in;

   // ---------------------------------------------------------------
   // memories: stack storage and roll scratch
   // ---------------------------------------------------------------
   logic [WORD_W-1:0] stack_mem [swr_pkg::STACK_DEPTH];
   logic [WORD_W-1:0] roll_mem  [swr_pkg::STACK_DEPTH];
   logic [WORD_W-1:0] stack_rd_ff;
   logic [WORD_W-1:0] roll_rd_ff;

   logic              stack_we;
   logic [ADDR_W-1:0] stack_wa;
   logic [WORD_W-1:0] stack_wd;
   logic [ADDR_W-1:0] stack_ra;
   logic [ADDR_W-1:0] roll_ra;
   logic [ADDR_W-1:0] depth_addr;   // top_ff - i_ff

   // ---------------------------------------------------------------
   // shared subtractor: mod steps and source index wrap
   // ---------------------------------------------------------------
   logic [N_W:0]   alu_a;
   logic [N_W-1:0] alu_b;
   logic [N_W+1:0] alu_diff;
   logic           alu_borrow;
   logic           alu_zero;

   always_comb begin
      if (state_ff == S_MOD) begin
         alu_a = {r_ff, k_ff[K_W-1]};
      end else begin
         alu_a = {1'b0, j_ff} + (N_W+1)'(1);
      end
      alu_b      = n_ff;
      alu_diff   = {1'b0, alu_a} - {2'b00, alu_b};
      alu_borrow = alu_diff[N_W+1];
      alu_zero   = (alu_diff == '0);
   end

   // ---------------------------------------------------------------
   // request decode helpers
   // ---------------------------------------------------------------
   logic             req_fire;
   logic             is_full;
   logic             is_empty;
   logic             roll_too_big;
   logic [EXT_W-1:0] push_ext;
   logic [WORD_W-1:0] push_word;
   logic [EXT_W-1:0] pop_ext;
   logic [CMP_W-1:0] fill_ext;

   assign req_ready    = (state_ff == S_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign is_full      = (count_ff >= CNT_W'(swr_pkg::STACK_DEPTH));
   assign is_empty     = (count_ff == '0);
   assign roll_too_big = (CMP_W'(req_roll_count) > CMP_W'(count_ff));
   // pushed word: sign-extend 32 bits, keep the stored width
   assign push_ext     = EXT_W'(req_push_value);
   assign push_word    = push_ext[WORD_W-1:0];
   // popped word: sign-extend stored width, return 32 bits
   assign pop_ext      = EXT_W'(signed'(stack_rd_ff));
   assign fill_ext     = CMP_W'(count_ff);
   assign depth_addr   = top_ff - ADDR_W'(i_ff);

   // memory port steering
   always_comb begin
      if (state_ff == S_IDLE) begin
         stack_ra = ADDR_W'(count_ff - CNT_W'(1));
      end else begin
         stack_ra = depth_addr;
      end
      roll_ra = ADDR_W'(j_ff);
      if (wb_pend_ff) begin
         stack_we = 1'b1;
         stack_wa = wb_addr_ff;
         stack_wd = roll_rd_ff;
      end else begin
         stack_we = req_fire && (req_op == swr_pkg::OP_PUSH) && !is_full;
         stack_wa = ADDR_W'(count_ff);
         stack_wd = push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
      stack_rd_ff <= stack_mem[stack_ra];
   end

   always_ff @(posedge clock) begin
      if (copy_pend_ff) begin
         roll_mem[copy_idx_ff] <= stack_rd_ff;
      end
      roll_rd_ff <= roll_mem[roll_ra];
   end

   // ---------------------------------------------------------------
   // sequencer next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      r_in         = r_ff;
      step_in      = step_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      left_in      = left_ff;
      top_in       = top_ff;
      res_pop_in   = res_pop_ff;
      res_stat_in  = res_stat_ff;
      copy_pend_in = (state_ff == S_COPY);
      copy_idx_in  = ADDR_W'(i_ff);
      wb_pend_in   = (state_ff == S_WBACK);
      wb_addr_in   = depth_addr;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pop_in   = rsp_pop_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_fill_in  = rsp_fill_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_pop_in  = '0;
               res_stat_in = swr_pkg::STAT_OK;
               state_in    = S_DONE;
               case (req_op)
                  swr_pkg::OP_PUSH: begin
                     if (is_full) begin
                        res_stat_in = swr_pkg::STAT_OVERFLOW;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  swr_pkg::OP_POP: begin
                     if (is_empty) begin
                        res_stat_in = swr_pkg::STAT_UNDERFLOW;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        state_in = S_POP;
                     end
                  end
                  swr_pkg::OP_ROLL: begin
                     if (roll_too_big) begin
                        res_stat_in = swr_pkg::STAT_ROLL_RANGE;
                     end else if (req_roll_count != '0) begin
                        n_in     = req_roll_count;
                        k_in     = req_roll_shift;
                        r_in     = '0;
                        step_in  = STEP_W'(swr_pkg::MOD_STEPS - 1);
                        top_in   = ADDR_W'(count_ff - CNT_W'(1));
                        state_in = S_MOD;
                     end
                  end
                  default: begin
                     // unused op code: no-op
                  end
               endcase
            end
         end
         S_POP: begin
            res_pop_in = pop_ext[DATA_W-1:0];
            state_in   = S_DONE;
         end
         S_MOD: begin
            // restoring step: keep the difference unless it went negative
            r_in    = alu_borrow ? alu_a[N_W-1:0] : alu_diff[N_W-1:0];
            k_in    = {k_ff[K_W-2:0], 1'b0};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               i_in     = '0;
               left_in  = n_ff - N_W'(1);
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            i_in    = i_ff + N_W'(1);
            left_in = left_ff - N_W'(1);
            if (left_ff == '0) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last scratch write lands this cycle
            i_in     = '0;
            j_in     = r_ff;
            left_in  = n_ff - N_W'(1);
            state_in = S_WBACK;
         end
         S_WBACK: begin
            i_in    = i_ff + N_W'(1);
            j_in    = alu_zero ? '0 : alu_a[N_W-1:0];
            left_in = left_ff - N_W'(1);
            if (left_ff == '0) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            // last stack write lands this cycle
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pop_in   = res_pop_ff;
               rsp_stat_in  = res_stat_ff;
               rsp_fill_in  = fill_ext[swr_pkg::FILL_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // state and registered outputs
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      k_ff        <= k_in;
      r_ff        <= r_in;
      step_ff     <= step_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      left_ff     <= left_in;
      top_ff      <= top_in;
      res_pop_ff  <= res_pop_in;
      res_stat_ff <= res_stat_in;
      copy_idx_ff <= copy_idx_in;
      wb_addr_ff  <= wb_addr_in;
      rsp_pop_ff  <= rsp_pop_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_fill_ff <= rsp_fill_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         copy_pend_ff <= 1'b0;
         wb_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         copy_pend_ff <= copy_pend_in;
         wb_pend_ff   <= wb_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pop_value  = rsp_pop_ff;
   assign rsp_status     = rsp_stat_ff;
   assign rsp_fill_level = rsp_fill_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(swr_pkg::STACK_DEPTH))
      else $error("fill level above stack depth");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside done state");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == swr_pkg::OP_PUSH && !is_full)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not advance fill level");

   a_roll_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COPY || state_ff == S_WBACK) |=> $stable(count_ff))
      else $error("fill level moved during roll");

   a_scratch_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(copy_pend_ff && wb_pend_ff))
      else $error("scratch copy and write back overlap");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the stack_with_roll block: push, pop and roll
// transactions are checked against a shadow stack. Depends on hdl/swr_pkg.sv
// and hdl/stack_with_roll.sv.
`timescale 1ns / 100ps

module testbench;

   // op code 3 is not decoded by the block; it must act as a no-op
   localparam logic [swr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 64;
   localparam int MAX_PRINTED  = 100;

   // one response, as the block presents it
   typedef struct packed {
      logic [swr_pkg::DATA_W-1:0] pop;
      swr_pkg::status_type        status;
      logic [swr_pkg::FILL_W-1:0] fill;
   } rsp_fields_type;

   // directed stimulus; a row with typed set carries its own expected response
   typedef struct packed {
      logic [swr_pkg::OP_W-1:0]   op;
      logic [swr_pkg::DATA_W-1:0] value;
      logic [swr_pkg::N_W-1:0]    roll_n;
      logic [swr_pkg::K_W-1:0]    roll_k;
      logic [7:0]                 reps;
      logic                       typed;
      logic [swr_pkg::DATA_W-1:0] pop;
      swr_pkg::status_type        status;
      logic [swr_pkg::FILL_W-1:0] fill;
   } dir_row_type;

   localparam int N_ROWS = 15;
   localparam dir_row_type DIRECTED [N_ROWS] = '{
      // empty stack: underflow, roll above fill, zero-count roll, unused op
      '{swr_pkg::OP_POP,  32'h0000_0000, 5'd0,  8'd0,   8'd1,
        1'b1, 32'd0, swr_pkg::STAT_UNDERFLOW,  5'd0},
      '{swr_pkg::OP_ROLL, 32'h0000_0000, 5'd1,  8'd0,   8'd1,
        1'b1, 32'd0, swr_pkg::STAT_ROLL_RANGE, 5'd0},
      '{swr_pkg::OP_ROLL, 32'h0000_0000, 5'd0,  8'd255, 8'd1,
        1'b1, 32'd0, swr_pkg::STAT_OK,         5'd0},
      '{OP_UNUSED,        32'hFFFF_FFFF, 5'd31, 8'd255, 8'd1,
        1'b1, 32'd0, swr_pkg::STAT_OK,         5'd0},
      // extreme words, then a swap of the two
      '{swr_pkg::OP_PUSH, 32'h7FFF_FFFF, 5'd0,  8'd0,   8'd1,
        1'b1, 32'd0, swr_pkg::STAT_OK,         5'd1},
      '{swr_pkg::OP_PUSH, 32'h8000_0000, 5'd0,  8'd0,   8'd1,
        1'b1, 32'd0, swr_pkg::STAT_OK,         5'd2},
      '{swr_pkg::OP_ROLL, 32'h0000_0000, 5'd2,  8'd1,   8'd1,
        1'b0, 32'd0, swr_pkg::STAT_OK,         5'd0},
      '{swr_pkg::OP_POP,  32'h0000_0000, 5'd0,  8'd0,   8'd1,
        1'b0, 32'd0, swr_pkg::STAT_OK,         5'd0},
      '{swr_pkg::OP_ROLL, 32'h0000_0000, 5'd31, 8'd0,   8'd1,
        1'b1, 32'd0, swr_pkg::STAT_ROLL_RANGE, 5'd1},
      // fill to the top, then overflow
      '{swr_pkg::OP_PUSH, 32'h1234_0000, 5'd0,  8'd0,   8'(swr_pkg::STACK_DEPTH - 1),
        1'b0, 32'd0, swr_pkg::STAT_OK,         5'd0},
      '{swr_pkg::OP_PUSH, 32'hFFFF_FFFF, 5'd0,  8'd0,   8'd1,
        1'b1, 32'd0, swr_pkg::STAT_OVERFLOW,
        swr_pkg::FILL_W'(swr_pkg::STACK_DEPTH)},
      // full-depth rolls, largest shift
      '{swr_pkg::OP_ROLL, 32'h0000_0000, 5'd16, 8'd255, 8'd1,
        1'b0, 32'd0, swr_pkg::STAT_OK,         5'd0},
      '{swr_pkg::OP_ROLL, 32'h0000_0000, 5'd16, 8'd3,   8'd1,
        1'b0, 32'd0, swr_pkg::STAT_OK,         5'd0},
      '{swr_pkg::OP_POP,  32'h0000_0000, 5'd0,  8'd0,   8'd1,
        1'b0, 32'd0, swr_pkg::STAT_OK,         5'd0},
      '{swr_pkg::OP_POP,  32'h0000_0000, 5'd0,  8'd0,   8'd1,
        1'b0, 32'd0, swr_pkg::STAT_OK,         5'd0}
   };

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [swr_pkg::OP_W-1:0]          req_op;
   logic signed [swr_pkg::DATA_W-1:0] req_push_value;
   logic [swr_pkg::N_W-1:0]           req_roll_count;
   logic [swr_pkg::K_W-1:0]           req_roll_shift;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic signed [swr_pkg::DATA_W-1:0] rsp_pop_value;
   logic [1:0]                        rsp_status;
   logic [swr_pkg::FILL_W-1:0]        rsp_fill_level;

   stack_with_roll dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_push_value (req_push_value),
      .req_roll_count (req_roll_count),
      .req_roll_shift (req_roll_shift),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_fill_level (rsp_fill_level)
   );

   // shadow copy of the stack; index 0 is the bottom entry
   logic [swr_pkg::WORD_WIDTH-1:0] shadow_words [swr_pkg::STACK_DEPTH];
   int                             shadow_fill;

   rsp_fields_type pending_rsp [$];   // responses still owed by the block

   int  mismatches    = 0;
   int  items_sent    = 0;
   int  results_seen  = 0;
   int  cycle_count   = 0;
   int  n_push = 0, n_pop = 0, n_roll = 0, n_unused = 0;
   int  n_overflow = 0, n_underflow = 0, n_range = 0;
   int  deepest_roll  = 0;
   bit  no_idle       = 1'b0;     // both sides run flat out while set

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_rsp.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // Applies one transaction to the shadow stack and returns the response
   // the block owes for it. Failed operations leave the stack alone.
   function automatic rsp_fields_type apply_op(
         input logic [swr_pkg::OP_W-1:0] op,
         input logic signed [swr_pkg::DATA_W-1:0] value,
         input logic [swr_pkg::N_W-1:0] roll_n,
         input logic [swr_pkg::K_W-1:0] roll_k);
      rsp_fields_type                        rsp;
      logic signed [63:0]                    wide;
      logic signed [swr_pkg::WORD_WIDTH-1:0] word;
      logic [swr_pkg::WORD_WIDTH-1:0]        group [swr_pkg::STACK_DEPTH];
      int                                    n, steps, top;
      rsp.pop    = '0;
      rsp.status = swr_pkg::STAT_OK;
      case (op)
         swr_pkg::OP_PUSH: begin
            n_push++;
            if (shadow_fill >= swr_pkg::STACK_DEPTH) begin
               rsp.status = swr_pkg::STAT_OVERFLOW;
               n_overflow++;
            end else begin
               wide = value;
               shadow_words[shadow_fill] = wide[swr_pkg::WORD_WIDTH-1:0];
               shadow_fill++;
            end
         end
         swr_pkg::OP_POP: begin
            n_pop++;
            if (shadow_fill == 0) begin
               rsp.status = swr_pkg::STAT_UNDERFLOW;
               n_underflow++;
            end else begin
               shadow_fill--;
               word = shadow_words[shadow_fill];
               wide = word;              // sign-extend the stored word
               rsp.pop = wide[swr_pkg::DATA_W-1:0];
            end
         end
         swr_pkg::OP_ROLL: begin
            n_roll++;
            n = roll_n;
            if (n > shadow_fill) begin
               rsp.status = swr_pkg::STAT_ROLL_RANGE;
               n_range++;
            end else if (n != 0) begin
               // depth i from the top takes what was at depth (i + k) mod n
               if (n > deepest_roll) deepest_roll = n;
               steps = roll_k % n;
               top   = shadow_fill - 1;
               for (int i = 0; i < n; i++) group[i] = shadow_words[top - i];
               for (int i = 0; i < n; i++)
                  shadow_words[top - i] = group[(i + steps) % n];
            end
         end
         default: n_unused++;
      endcase
      rsp.fill = swr_pkg::FILL_W'(shadow_fill);
      return rsp;
   endfunction

   // Idle cycles before the next request: mostly none or a few, rarely long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Called at a falling edge. Holds the request until it is taken, then
   // records the owed response and returns at the next falling edge.
   task automatic offer_op(input logic [swr_pkg::OP_W-1:0] op,
                           input logic signed [swr_pkg::DATA_W-1:0] value,
                           input logic [swr_pkg::N_W-1:0] roll_n,
                           input logic [swr_pkg::K_W-1:0] roll_k,
                           input bit typed,
                           input rsp_fields_type typed_rsp);
      rsp_fields_type predicted;
      req_valid      <= 1'b1;
      req_op         <= op;
      req_push_value <= value;
      req_roll_count <= roll_n;
      req_roll_shift <= roll_k;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_op(op, value, roll_n, roll_k);
      // a typed row still runs through the shadow stack to keep it in step
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic idle_before_next();
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Response checker: every accepted transaction is matched in order.
   always @(posedge clock) begin
      rsp_fields_type owed;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch($sformatf(
               "response with nothing outstanding: pop %0d status %0d fill %0d",
               rsp_pop_value, rsp_status, rsp_fill_level));
         end else begin
            owed = pending_rsp.pop_front();
            if (rsp_pop_value !== owed.pop)
               report_mismatch($sformatf("response %0d pop_value %0d, expected %0d",
                                         results_seen, rsp_pop_value,
                                         $signed(owed.pop)));
            if (rsp_status !== owed.status)
               report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                         results_seen, rsp_status, owed.status));
            if (rsp_fill_level !== owed.fill)
               report_mismatch($sformatf("response %0d fill_level %0d, expected %0d",
                                         results_seen, rsp_fill_level, owed.fill));
         end
         results_seen++;
      end
   end

   // Receiver: random back-pressure, one long hold-off while the sender
   // keeps pushing so the block backs up and drops req_ready.
   initial begin
      int  hold_left;
      int  r;
      bit  long_hold_done;
      hold_left      = 0;
      long_hold_done = 1'b0;
      rsp_ready      = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (!long_hold_done && results_seen >= 400) begin
            long_hold_done = 1'b1;
            hold_left      = 300;
            rsp_ready     <= 1'b0;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_ready <= 1'b1;
            end else if (r < 96) begin
               rsp_ready <= 1'b0;
               hold_left  = $urandom_range(0, 3);
            end else begin
               rsp_ready <= 1'b0;
               hold_left  = $urandom_range(10, 40);
            end
         end
         @(negedge clock);
      end
   end

   // Sender: directed table, then random traffic that swings the stack
   // between empty and full so both ends and deep rolls get exercised.
   initial begin
      rsp_fields_type                    typed_rsp;
      logic [swr_pkg::OP_W-1:0]          op;
      logic signed [swr_pkg::DATA_W-1:0] value;
      logic [swr_pkg::N_W-1:0]           roll_n;
      logic [swr_pkg::K_W-1:0]           roll_k;
      bit  filling;
      int  tide_left;
      int  r;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = swr_pkg::OP_PUSH;
      req_push_value = '0;
      req_roll_count = '0;
      req_roll_shift = '0;
      shadow_fill    = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int row = 0; row < N_ROWS; row++) begin
         for (int rep = 0; rep < DIRECTED[row].reps; rep++) begin
            typed_rsp = '{DIRECTED[row].pop, DIRECTED[row].status,
                          DIRECTED[row].fill};
            idle_before_next();
            offer_op(DIRECTED[row].op, DIRECTED[row].value + rep,
                     DIRECTED[row].roll_n, DIRECTED[row].roll_k,
                     DIRECTED[row].typed, typed_rsp);
         end
      end

      filling   = 1'b1;
      tide_left = $urandom_range(20, 80);
      for (int item = 0; item < RANDOM_ITEMS; item++) begin
         no_idle = (item >= 300 && item < 450);
         // once, let the block drain completely before carrying on
         if (item == 900) begin
            req_valid <= 1'b0;
            while (pending_rsp.size() != 0) @(negedge clock);
         end
         if (tide_left == 0) begin
            filling   = !filling;
            tide_left = $urandom_range(20, 80);
         end
         tide_left--;

         r = $urandom_range(0, 99);
         if (r < (filling ? 50 : 20))      op = swr_pkg::OP_PUSH;
         else if (r < (filling ? 70 : 55)) op = swr_pkg::OP_POP;
         else if (r < 97)                  op = swr_pkg::OP_ROLL;
         else                              op = OP_UNUSED;

         value = $urandom;
         if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 3))
               0:       value = 32'h0000_0000;
               1:       value = 32'hFFFF_FFFF;
               2:       value = 32'h7FFF_FFFF;
               default: value = 32'h8000_0000;
            endcase
         end

         // roll counts mostly within the fill level, some zero, some wild
         r = $urandom_range(0, 99);
         if (r < 80)
            roll_n = (shadow_fill == 0) ? '0
                     : swr_pkg::N_W'($urandom_range(1,
                          (shadow_fill > 31) ? 31 : shadow_fill));
         else if (r < 88)
            roll_n = '0;
         else
            roll_n = swr_pkg::N_W'($urandom_range(0, 31));
         roll_k = swr_pkg::K_W'($urandom_range(0, 255));

         idle_before_next();
         offer_op(op, value, roll_n, roll_k, 1'b0, '0);
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d transactions (%0d push, %0d pop, %0d roll, %0d unused op)",
               items_sent, n_push, n_pop, n_roll, n_unused);
      $display("%0d responses checked; %0d overflow, %0d underflow, %0d roll %s %0d",
               results_seen, n_overflow, n_underflow, n_range,
               "above fill; deepest roll", deepest_roll);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/swr_pkg.sv
hdl/stack_with_roll.sv
tb/testbench.sv
